// ----- hw/rtl/wat_pkg.sv -----
package wat_pkg;

    // Default table depth
    localparam int NUM_ALARMS_DEF = 16;

    // Time constants in minutes
    localparam int MIN_PER_HOUR   = 60;
    localparam int DAY_MINUTES    = 24 * 60;
    localparam int WINDOW_MINUTES = 23 * 60;
    localparam int LAST_WEEKDAY   = 6;

    // Widths of time values
    localparam int TIME_W = 11;
    localparam int DIST_W = 13;

    // Request command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Result kind codes
    localparam logic KIND_FIRE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // One alarm table entry
    typedef struct packed {
        logic       enabled;
        logic [2:0] unit;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       one_time;
        logic [6:0] days;
        logic [7:0] volume;
    } alarm_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_SUMMARY
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic write_slot;
        logic issue;
        logic summary;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

// ----- hw/rtl/wat_ctrl.sv -----
module wat_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    output logic                busy,
    output wat_pkg::dp_cmd_t    dp_cmd,
    input  wat_pkg::dp_status_t dp_status
);
    import wat_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = (cmd == CMD_TICK) ? ST_SCAN : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                dp_cmd.write_slot = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_SCAN:
            begin
                dp_cmd.issue = 1'b1;
                if (dp_status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SUMMARY;
            end
            ST_SUMMARY:
            begin
                dp_cmd.summary = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/wat_datapath.sv -----
module wat_datapath #(
    parameter int NUM_ALARMS = wat_pkg::NUM_ALARMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wat_pkg::dp_cmd_t    dp_cmd,
    output wat_pkg::dp_status_t dp_status,
    input  logic [3:0]          slot,
    input  logic                enabled,
    input  logic [2:0]          unit,
    input  logic [4:0]          alarm_hour,
    input  logic [5:0]          alarm_minute,
    input  logic                one_time,
    input  logic [6:0]          day_mask,
    input  logic [7:0]          volume,
    input  logic [2:0]          now_weekday,
    input  logic [4:0]          now_hour,
    input  logic [5:0]          now_minute,
    output logic                valid,
    output logic                kind,
    output logic [3:0]          fired_slot,
    output logic [2:0]          fired_unit,
    output logic [7:0]          fired_volume,
    output logic                next_valid,
    output logic [10:0]         next_in_minutes,
    output logic [4:0]          next_hour,
    output logic [5:0]          next_minute,
    output logic                last
);
    import wat_pkg::*;

    localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    // Alarm memory with one valid bit per entry
    alarm_t                  mem [NUM_ALARMS];
    logic [NUM_ALARMS-1:0]   mem_valid_reg;
    logic [NUM_ALARMS-1:0]   sig_reg;

    // Latched request
    logic [3:0]        slot_reg;
    alarm_t            wr_entry_reg;
    logic [2:0]        wday_reg;
    logic [4:0]        now_hour_reg;
    logic [5:0]        now_minute_reg;
    logic [TIME_W-1:0] now_min_reg;

    // Scan pipeline
    logic [IDX_W-1:0] cnt_reg;
    logic             eval_en_reg;
    logic [IDX_W-1:0] eval_idx_reg;
    alarm_t           rd_data_reg;
    logic             rd_valid_reg;

    // Nearest alarm so far
    logic              have_best_reg;
    logic [10:0]       best_reg;
    logic [4:0]        best_hour_reg;
    logic [5:0]        best_minute_reg;

    // Result registers
    logic        valid_reg;
    logic        kind_reg;
    logic [3:0]  fired_slot_reg;
    logic [2:0]  fired_unit_reg;
    logic [7:0]  fired_volume_reg;
    logic        next_valid_reg;
    logic [10:0] next_in_minutes_reg;
    logic [4:0]  next_hour_reg;
    logic [5:0]  next_minute_reg;
    logic        last_reg;

    // Evaluation signals
    alarm_t                   entry;
    logic [TIME_W-1:0]        at_min;
    logic signed [DIST_W-1:0] d_today;
    logic signed [DIST_W-1:0] d_tom;
    logic signed [DIST_W-1:0] dist_min;
    logic                     pending;
    logic [7:0]               days8;
    logic [2:0]               tomorrow;
    logic                     today_set;
    logic                     tom_set;
    logic                     at_ahead;
    logic                     fire;
    logic                     cand;
    logic                     better;
    logic                     time_match;
    logic                     slot_in_range;
    logic [IDX_W-1:0]         wr_addr;

    assign dp_status.scan_last = (cnt_reg == IDX_W'(NUM_ALARMS - 1));
    assign slot_in_range       = ({3'b000, slot_reg} < 7'(NUM_ALARMS));
    assign wr_addr             = IDX_W'(slot_reg);

    // Latch the request and prepare a scan
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            slot_reg                <= slot;
            wr_entry_reg.enabled    <= enabled;
            wr_entry_reg.unit       <= unit;
            wr_entry_reg.hour       <= alarm_hour;
            wr_entry_reg.minute     <= alarm_minute;
            wr_entry_reg.one_time   <= one_time;
            wr_entry_reg.days       <= day_mask;
            wr_entry_reg.volume     <= volume;
            wday_reg                <= now_weekday;
            now_hour_reg            <= now_hour;
            now_minute_reg          <= now_minute;
            now_min_reg             <= TIME_W'(now_hour) * TIME_W'(MIN_PER_HOUR)
                                       + TIME_W'(now_minute);
        end
    end

    // Scan counter and read pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            eval_en_reg <= 1'b0;
        end
        else
        begin
            eval_en_reg <= dp_cmd.issue;
            if (dp_cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (dp_cmd.issue)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.write_slot && slot_in_range)
        begin
            mem[wr_addr] <= wr_entry_reg;
        end
        else if (eval_en_reg && fire && entry.one_time)
        begin
            mem[eval_idx_reg] <= {1'b0, entry[$bits(alarm_t)-2:0]};
        end
        if (dp_cmd.issue)
        begin
            rd_data_reg <= mem[cnt_reg];
        end
        eval_idx_reg <= cnt_reg;
    end

    // Valid bits of the memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (dp_cmd.write_slot && slot_in_range)
            begin
                mem_valid_reg[wr_addr] <= 1'b1;
            end
            if (dp_cmd.issue)
            begin
                rd_valid_reg <= mem_valid_reg[cnt_reg];
            end
        end
    end

    // Distance to the alarm under evaluation
    always_comb
    begin
        entry     = rd_valid_reg ? rd_data_reg : '0;
        at_min    = TIME_W'(entry.hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(entry.minute);
        d_today   = $signed({2'b00, at_min}) - $signed({2'b00, now_min_reg});
        d_tom     = d_today + DIST_W'(DAY_MINUTES);
        at_ahead  = (at_min >= now_min_reg);
        days8     = {1'b0, entry.days};
        tomorrow  = (wday_reg < 3'(LAST_WEEKDAY)) ? (wday_reg + 3'd1) : 3'd0;
        today_set = days8[wday_reg];
        tom_set   = days8[tomorrow];
        pending   = 1'b0;
        dist_min  = d_tom;
        if (entry.enabled)
        begin
            if (entry.one_time)
            begin
                pending  = 1'b1;
                dist_min = at_ahead ? d_today : d_tom;
            end
            else if (today_set && at_ahead)
            begin
                pending  = 1'b1;
                dist_min = d_today;
            end
            else if (tom_set)
            begin
                pending  = 1'b1;
                dist_min = d_tom;
            end
        end
        // Out-of-range tick times can make the distance negative; such an alarm is no candidate.
        fire       = pending && (dist_min == '0) && !sig_reg[eval_idx_reg];
        cand       = pending && !dist_min[DIST_W-1] && (dist_min != '0)
                     && (dist_min < DIST_W'(WINDOW_MINUTES));
        better     = cand && (!have_best_reg || (dist_min[10:0] < best_reg));
        time_match = (entry.hour == now_hour_reg) && (entry.minute == now_minute_reg);
    end

    // Signalled flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg <= '0;
        end
        else if (dp_cmd.write_slot && slot_in_range)
        begin
            sig_reg[wr_addr] <= 1'b0;
        end
        else if (eval_en_reg)
        begin
            sig_reg[eval_idx_reg] <= (sig_reg[eval_idx_reg] | fire) & time_match;
        end
    end

    // Nearest alarm tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
        end
        else if (dp_cmd.load)
        begin
            have_best_reg <= 1'b0;
        end
        else if (eval_en_reg && better)
        begin
            have_best_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_en_reg && better)
        begin
            best_reg        <= dist_min[10:0];
            best_hour_reg   <= entry.hour;
            best_minute_reg <= entry.minute;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= (eval_en_reg && fire) || dp_cmd.summary;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.summary)
        begin
            kind_reg            <= KIND_SUMMARY;
            fired_slot_reg      <= 4'd0;
            fired_unit_reg      <= 3'd0;
            fired_volume_reg    <= 8'd0;
            next_valid_reg      <= have_best_reg;
            next_in_minutes_reg <= have_best_reg ? best_reg : 11'd0;
            next_hour_reg       <= have_best_reg ? best_hour_reg : 5'd0;
            next_minute_reg     <= have_best_reg ? best_minute_reg : 6'd0;
            last_reg            <= 1'b1;
        end
        else if (eval_en_reg && fire)
        begin
            kind_reg            <= KIND_FIRE;
            fired_slot_reg      <= 4'(eval_idx_reg);
            fired_unit_reg      <= entry.unit;
            fired_volume_reg    <= entry.volume;
            next_valid_reg      <= 1'b0;
            next_in_minutes_reg <= 11'd0;
            next_hour_reg       <= 5'd0;
            next_minute_reg     <= 6'd0;
            last_reg            <= 1'b0;
        end
    end

    assign valid           = valid_reg;
    assign kind            = kind_reg;
    assign fired_slot      = fired_slot_reg;
    assign fired_unit      = fired_unit_reg;
    assign fired_volume    = fired_volume_reg;
    assign next_valid      = next_valid_reg;
    assign next_in_minutes = next_in_minutes_reg;
    assign next_hour       = next_hour_reg;
    assign next_minute     = next_minute_reg;
    assign last            = last_reg;

endmodule

// ----- hw/rtl/weekly_alarm_table_scanner.sv -----
// Weekly alarm table scanner.
// A request is taken when start is high and busy is low; cmd selects a slot
// write or a tick carrying the current weekday, hour and minute.
// A write stores one alarm slot, clears its signalled flag and gives no
// result; busy stays high for one cycle after the request.
// A tick walks the table one slot per cycle through a single read port of
// the alarm memory, keeping busy high through its scan, drain and summary
// states; the next request is taken in the cycle in which the summary is
// shown. Each result is shown for one cycle, marked by valid: zero or more
// fire results in slot order, then one summary with last set, registered
// from the summary state.
// The receiver cannot stall; results are never held back.
// Reset disables every alarm and clears all signalled flags at once; no
// clearing pass is needed, so a request may follow reset immediately.
module weekly_alarm_table_scanner #(
    parameter int NUM_ALARMS = wat_pkg::NUM_ALARMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [3:0]  slot,
    input  logic        enabled,
    input  logic [2:0]  unit,
    input  logic [4:0]  alarm_hour,
    input  logic [5:0]  alarm_minute,
    input  logic        one_time,
    input  logic [6:0]  day_mask,
    input  logic [7:0]  volume,
    input  logic [2:0]  now_weekday,
    input  logic [4:0]  now_hour,
    input  logic [5:0]  now_minute,
    output logic        valid,
    output logic        kind,
    output logic [3:0]  fired_slot,
    output logic [2:0]  fired_unit,
    output logic [7:0]  fired_volume,
    output logic        next_valid,
    output logic [10:0] next_in_minutes,
    output logic [4:0]  next_hour,
    output logic [5:0]  next_minute,
    output logic        last
);
    import wat_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequencer
    wat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    // Alarm table and scan datapath
    wat_datapath #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status),
        .slot            (slot),
        .enabled         (enabled),
        .unit            (unit),
        .alarm_hour      (alarm_hour),
        .alarm_minute    (alarm_minute),
        .one_time        (one_time),
        .day_mask        (day_mask),
        .volume          (volume),
        .now_weekday     (now_weekday),
        .now_hour        (now_hour),
        .now_minute      (now_minute),
        .valid           (valid),
        .kind            (kind),
        .fired_slot      (fired_slot),
        .fired_unit      (fired_unit),
        .fired_volume    (fired_volume),
        .next_valid      (next_valid),
        .next_in_minutes (next_in_minutes),
        .next_hour       (next_hour),
        .next_minute     (next_minute),
        .last            (last)
    );

endmodule

// ----- dv/alarm_scan_checker.sv -----
module alarm_scan_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        cmd,
    input  logic [3:0]  slot,
    input  logic        enabled,
    input  logic [2:0]  unit,
    input  logic [4:0]  alarm_hour,
    input  logic [5:0]  alarm_minute,
    input  logic        one_time,
    input  logic [6:0]  day_mask,
    input  logic [7:0]  volume,
    input  logic [2:0]  now_weekday,
    input  logic [4:0]  now_hour,
    input  logic [5:0]  now_minute,
    input  logic        valid,
    input  logic        kind,
    input  logic [3:0]  fired_slot,
    input  logic [2:0]  fired_unit,
    input  logic [7:0]  fired_volume,
    input  logic        next_valid,
    input  logic [10:0] next_in_minutes,
    input  logic [4:0]  next_hour,
    input  logic [5:0]  next_minute,
    input  logic        last,
    output int          mismatch_count,
    output int          results_pending
);
    import wat_pkg::*;

    localparam int NUM_SLOTS = NUM_ALARMS_DEF;

    typedef struct packed {
        logic        kind;
        logic [3:0]  fired_slot;
        logic [2:0]  fired_unit;
        logic [7:0]  fired_volume;
        logic        next_valid;
        logic [10:0] next_in_minutes;
        logic [4:0]  next_hour;
        logic [5:0]  next_minute;
        logic        last;
    } result_t;

    // Our own copy of the alarm table and the per-slot signalled flags.
    alarm_t                alarms [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  signalled;
    result_t               expected_results [$];
    result_t               seen;

    // Minutes until the alarm goes off, or a negative value when it is not pending.
    function automatic int minutes_until(alarm_t a, logic [2:0] wday, int now_min);
        int         at;
        logic [2:0] tomorrow;
        logic [7:0] days;
        if (!a.enabled)
            return -1;
        at = int'(a.hour) * MIN_PER_HOUR + int'(a.minute);
        if (a.one_time)
            return (at >= now_min) ? at - now_min : at + DAY_MINUTES - now_min;
        // A weekday of seven looks at a mask bit that is never set.
        tomorrow = (int'(wday) < LAST_WEEKDAY) ? wday + 3'd1 : 3'd0;
        days = {1'b0, a.days};
        if (days[wday] && at >= now_min)
            return at - now_min;
        if (days[tomorrow])
            return at + DAY_MINUTES - now_min;
        return -1;
    endfunction

    // A write fills one slot and clears its signalled flag.
    function automatic void store_alarm();
        alarm_t a;
        a.enabled  = enabled;
        a.unit     = unit;
        a.hour     = alarm_hour;
        a.minute   = alarm_minute;
        a.one_time = one_time;
        a.days     = day_mask;
        a.volume   = volume;
        if (int'(slot) < NUM_SLOTS)
        begin
            alarms[slot]    = a;
            signalled[slot] = 1'b0;
        end
    endfunction

    // Walk the table for one tick: fire results in slot order, then the summary.
    function automatic void predict_tick(logic [2:0] wday, logic [4:0] hour,
                                         logic [5:0] minute);
        int         now_min;
        int         dist_min;
        int         best;
        logic       have_best;
        logic [4:0] best_hour;
        logic [5:0] best_minute;
        result_t    res;
        now_min     = int'(hour) * MIN_PER_HOUR + int'(minute);
        have_best   = 1'b0;
        best        = 0;
        best_hour   = '0;
        best_minute = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            dist_min = minutes_until(alarms[i], wday, now_min);
            if (dist_min == 0 && !signalled[i])
            begin
                res              = '0;
                res.kind         = KIND_FIRE;
                res.fired_slot   = 4'(i);
                res.fired_unit   = alarms[i].unit;
                res.fired_volume = alarms[i].volume;
                expected_results.insert(expected_results.size(), res);
                signalled[i] = 1'b1;
                if (alarms[i].one_time)
                    alarms[i].enabled = 1'b0;
            end
            else if (dist_min > 0 && dist_min < WINDOW_MINUTES)
            begin
                // Strictly smaller only, so the lowest slot wins a tie.
                if (!have_best || dist_min < best)
                begin
                    have_best   = 1'b1;
                    best        = dist_min;
                    best_hour   = alarms[i].hour;
                    best_minute = alarms[i].minute;
                end
            end
            if (alarms[i].hour != hour || alarms[i].minute != minute)
                signalled[i] = 1'b0;
        end
        res      = '0;
        res.kind = KIND_SUMMARY;
        if (have_best)
        begin
            res.next_valid      = 1'b1;
            res.next_in_minutes = 11'(best);
            res.next_hour       = best_hour;
            res.next_minute     = best_minute;
        end
        res.last = 1'b1;
        expected_results.insert(expected_results.size(), res);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with no request outstanding: kind %0d, slot %0d",
                   got.kind, got.fired_slot);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("fired_slot", want.fired_slot, got.fired_slot);
        compare_field("fired_unit", want.fired_unit, got.fired_unit);
        compare_field("fired_volume", want.fired_volume, got.fired_volume);
        compare_field("next_valid", want.next_valid, got.next_valid);
        compare_field("next_in_minutes", want.next_in_minutes, got.next_in_minutes);
        compare_field("next_hour", want.next_hour, got.next_hour);
        compare_field("next_minute", want.next_minute, got.next_minute);
        compare_field("last", want.last, got.last);
    endfunction

    // Sample at the rising edge: results first, then any request taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                alarms[i] = '0;
            signalled = '0;
            expected_results.delete();
        end
        else
        begin
            if (valid)
            begin
                seen = {kind, fired_slot, fired_unit, fired_volume, next_valid,
                        next_in_minutes, next_hour, next_minute, last};
                check_result(seen);
            end
            if (start && !busy)
            begin
                if (cmd == CMD_WRITE)
                    store_alarm();
                else
                    predict_tick(now_weekday, now_hour, now_minute);
            end
        end
        results_pending = expected_results.size();
    end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    import wat_pkg::*;

    localparam int TICK_CYCLES = NUM_ALARMS_DEF + 2;
    localparam int RANDOM_ITEMS = 450;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [3:0]  slot;
    logic        enabled;
    logic [2:0]  unit;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic        one_time;
    logic [6:0]  day_mask;
    logic [7:0]  volume;
    logic [2:0]  now_weekday;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic        valid;
    logic        kind;
    logic [3:0]  fired_slot;
    logic [2:0]  fired_unit;
    logic [7:0]  fired_volume;
    logic        next_valid;
    logic [10:0] next_in_minutes;
    logic [4:0]  next_hour;
    logic [5:0]  next_minute;
    logic        last;
    int          mismatch_count;
    int          results_pending;

    // No gaps between requests while this is set.
    logic        quiet_stretch = 1'b0;

    weekly_alarm_table_scanner DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .slot            (slot),
        .enabled         (enabled),
        .unit            (unit),
        .alarm_hour      (alarm_hour),
        .alarm_minute    (alarm_minute),
        .one_time        (one_time),
        .day_mask        (day_mask),
        .volume          (volume),
        .now_weekday     (now_weekday),
        .now_hour        (now_hour),
        .now_minute      (now_minute),
        .valid           (valid),
        .kind            (kind),
        .fired_slot      (fired_slot),
        .fired_unit      (fired_unit),
        .fired_volume    (fired_volume),
        .next_valid      (next_valid),
        .next_in_minutes (next_in_minutes),
        .next_hour       (next_hour),
        .next_minute     (next_minute),
        .last            (last)
    );

    alarm_scan_checker alarm_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .slot            (slot),
        .enabled         (enabled),
        .unit            (unit),
        .alarm_hour      (alarm_hour),
        .alarm_minute    (alarm_minute),
        .one_time        (one_time),
        .day_mask        (day_mask),
        .volume          (volume),
        .now_weekday     (now_weekday),
        .now_hour        (now_hour),
        .now_minute      (now_minute),
        .valid           (valid),
        .kind            (kind),
        .fired_slot      (fired_slot),
        .fired_unit      (fired_unit),
        .fired_volume    (fired_volume),
        .next_valid      (next_valid),
        .next_in_minutes (next_in_minutes),
        .next_hour       (next_hour),
        .next_minute     (next_minute),
        .last            (last),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drop start for a few cycles.
    task automatic pause(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Present one request at the falling edge and hold it until the block takes it.
    task automatic send_request(logic c, logic [3:0] s, logic en, logic [2:0] u,
                                logic [4:0] ah, logic [5:0] am, logic ot,
                                logic [6:0] dm, logic [7:0] vol, logic [2:0] wd,
                                logic [4:0] nh, logic [5:0] nm);
        if (!quiet_stretch && $urandom_range(99) < 12)
            pause($urandom_range(1, 6));
        @(negedge clk);
        cmd          <= c;
        slot         <= s;
        enabled      <= en;
        unit         <= u;
        alarm_hour   <= ah;
        alarm_minute <= am;
        one_time     <= ot;
        day_mask     <= dm;
        volume       <= vol;
        now_weekday  <= wd;
        now_hour     <= nh;
        now_minute   <= nm;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // The tick fields carry junk on a write, and the write fields on a tick.
    task automatic write_alarm(logic [3:0] s, logic en, logic [2:0] u, logic [4:0] h,
                               logic [5:0] m, logic ot, logic [6:0] dm, logic [7:0] vol);
        send_request(CMD_WRITE, s, en, u, h, m, ot, dm, vol,
                     3'($urandom), 5'($urandom), 6'($urandom));
    endtask

    task automatic tick(logic [2:0] wd, logic [4:0] h, logic [5:0] m);
        send_request(CMD_TICK, 4'($urandom), 1'($urandom), 3'($urandom), 5'($urandom),
                     6'($urandom), 1'($urandom), 7'($urandom), 8'($urandom), wd, h, m);
    endtask

    initial
    begin
        int random_items;
        int cur_wday;
        int cur_min;
        int pick;
        int t;
        logic [4:0] h;
        logic [5:0] m;
        logic [6:0] dm;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_WRITE;
        slot         = '0;
        enabled      = 1'b0;
        unit         = '0;
        alarm_hour   = '0;
        alarm_minute = '0;
        one_time     = 1'b0;
        day_mask     = '0;
        volume       = '0;
        now_weekday  = '0;
        now_hour     = '0;
        now_minute   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: the summary finds nothing.
        tick(3'd3, 5'd12, 6'd0);
        // Repeating alarm at the last minute of the day, one-time alarm at midnight.
        write_alarm(4'd0, 1'b1, 3'd7, 5'd23, 6'd59, 1'b0, 7'h7F, 8'hFF);
        write_alarm(4'd15, 1'b1, 3'd0, 5'd0, 6'd0, 1'b1, 7'h00, 8'h00);
        tick(3'd6, 5'd23, 6'd59);
        // Already signalled: no second fire at the same minute.
        tick(3'd6, 5'd23, 6'd59);
        // Rewriting the slot clears its flag, so it fires again.
        write_alarm(4'd0, 1'b1, 3'd7, 5'd23, 6'd59, 1'b0, 7'h7F, 8'hFF);
        tick(3'd6, 5'd23, 6'd59);
        // The one-time alarm fires after midnight and then disables itself.
        tick(3'd0, 5'd0, 6'd0);
        tick(3'd0, 5'd0, 6'd0);
        // Sunday-only alarm seen from the out-of-range weekday, from Saturday and on Sunday.
        write_alarm(4'd1, 1'b1, 3'd3, 5'd10, 6'd0, 1'b0, 7'h01, 8'h80);
        tick(3'd7, 5'd10, 6'd0);
        tick(3'd7, 5'd12, 6'd0);
        tick(3'd6, 5'd10, 6'd30);
        tick(3'd0, 5'd9, 6'd59);
        tick(3'd0, 5'd10, 6'd0);
        // Hour and minute beyond their ranges still match an equal tick time.
        write_alarm(4'd2, 1'b1, 3'd5, 5'd31, 6'd63, 1'b1, 7'h7F, 8'h55);
        tick(3'd5, 5'd31, 6'd63);
        // A disabled alarm never fires; two alarms tie and the lower slot wins.
        write_alarm(4'd3, 1'b0, 3'd2, 5'd8, 6'd15, 1'b0, 7'h7F, 8'h2A);
        write_alarm(4'd4, 1'b1, 3'd1, 5'd8, 6'd20, 1'b0, 7'h7F, 8'h01);
        write_alarm(4'd5, 1'b1, 3'd6, 5'd8, 6'd20, 1'b1, 7'h00, 8'h02);
        tick(3'd2, 5'd8, 6'd15);
        tick(3'd2, 5'd8, 6'd20);

        // Random part: a clock that mostly walks forward, with alarms set near it.
        cur_wday     = 2;
        cur_min      = 8 * 60 + 21;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            quiet_stretch = (random_items >= 150 && random_items < 280);
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                // Every slot due at once: the longest burst of fire results.
                for (int s = 0; s < NUM_ALARMS_DEF; s++)
                    write_alarm(4'(s), 1'b1, 3'($urandom), 5'(cur_min / 60),
                                6'(cur_min % 60), 1'($urandom), 7'h7F, 8'($urandom));
                tick(3'(cur_wday), 5'(cur_min / 60), 6'(cur_min % 60));
                random_items += NUM_ALARMS_DEF + 1;
            end
            else if (pick < 6)
            begin
                // Alarm time outside the normal range, then a tick at that time.
                h = 5'($urandom_range(0, 31));
                m = 6'($urandom_range(0, 63));
                if ($urandom_range(1) == 1)
                    h = 5'($urandom_range(24, 31));
                else
                    m = 6'($urandom_range(60, 63));
                write_alarm(4'($urandom), 1'b1, 3'($urandom), h, m, 1'($urandom),
                            7'h7F, 8'($urandom));
                tick(3'($urandom_range(0, 7)), h, m);
                random_items += 2;
            end
            else if (pick < 34)
            begin
                t = $urandom_range(99);
                if (t < 70)
                    t = (cur_min + $urandom_range(0, 4) - 1 + DAY_MINUTES) % DAY_MINUTES;
                else if (t < 90)
                    t = $urandom_range(0, DAY_MINUTES - 1);
                else
                    t = -1;
                if (t < 0)
                begin
                    h = 5'($urandom);
                    m = 6'($urandom);
                end
                else
                begin
                    h = 5'(t / 60);
                    m = 6'(t % 60);
                end
                dm = ($urandom_range(1) == 1) ? 7'h7F : 7'($urandom);
                write_alarm(4'($urandom), $urandom_range(99) < 88, 3'($urandom), h, m,
                            $urandom_range(99) < 40, dm, 8'($urandom));
                random_items++;
            end
            else
            begin
                t = $urandom_range(99);
                if (t < 95)
                begin
                    if (t < 55)
                        cur_min += 1;
                    else if (t < 75)
                        cur_min += 0;
                    else if (t < 85)
                        cur_min += $urandom_range(2, 120);
                    else
                    begin
                        cur_wday = $urandom_range(0, 6);
                        cur_min  = $urandom_range(0, DAY_MINUTES - 1);
                    end
                    while (cur_min >= DAY_MINUTES)
                    begin
                        cur_min -= DAY_MINUTES;
                        cur_wday = (cur_wday + 1) % 7;
                    end
                    tick(3'(cur_wday), 5'(cur_min / 60), 6'(cur_min % 60));
                end
                else
                    // Stray tick over the full width of the time fields.
                    tick(3'($urandom), 5'($urandom), 6'($urandom));
                random_items++;
            end
        end

        // Drain and let the block settle before the verdict.
        @(negedge clk);
        start <= 1'b0;
        do
            @(negedge clk);
        while (results_pending != 0);
        repeat (4 * TICK_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a hung handshake or a result that never arrives.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
